FILE: design/depth_pixel_backprojection_assert.svh
// Assertion macros shared by the depth pixel back-projection RTL.
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

`ifndef SYNTHESIS

// Check a same-cycle implication under reset.
`define DPB_ASSERT_IMP(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("depth_pixel_backprojection: assertion failed");

// Check a next-cycle implication under reset.
`define DPB_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("depth_pixel_backprojection: assertion failed");

`else

`define DPB_ASSERT_IMP(label, clock, resetn, ante, cons)
`define DPB_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

FILE: design/dpb_pkg.sv
// Types, constants and helper functions for the depth pixel back-projection block.
package dpb_pkg;

    // Pixel subsampling stride
    localparam int unsigned SUBSAMPLE_STRIDE = 3;

    // Register stages in the pipeline, input capture through output register
    localparam int unsigned NUM_STAGES = 8;

    // Reciprocal for the stride test: quotient = (v * STRIDE_RECIP) >> STRIDE_SHIFT
    localparam int unsigned STRIDE_SHIFT = 24;
    localparam longint unsigned STRIDE_RECIP =
        ((64'd1 << STRIDE_SHIFT) + SUBSAMPLE_STRIDE - 1) / SUBSAMPLE_STRIDE;

    // Depth window on the Q4.12 grid: 0.01 m to 10 m
    localparam logic [15:0] DEPTH_MIN_Q = 16'd41;
    localparam logic [15:0] DEPTH_MAX_Q = 16'd40960;

    // Output saturation limits, signed Q12.12
    localparam logic signed [32:0] OUT_MAX = 33'sd8388607;
    localparam logic signed [32:0] OUT_MIN = -33'sd8388608;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_RECIP_FOCAL_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RECIP_FOCAL_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POSE_ROW_ZERO = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_POSE_ROW_ONE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_POSE_ROW_TWO  = 3'd6;

    // Configuration reset values (identity pose)
    localparam logic [23:0] RESET_RECIP_FOCAL = 24'd33554;
    localparam logic [15:0] RESET_CENTER_X    = 16'd5120;
    localparam logic [15:0] RESET_CENTER_Y    = 16'd3840;
    localparam logic [63:0] RESET_POSE_ROW_ZERO = 64'h4000_0000_0000_0000;
    localparam logic [63:0] RESET_POSE_ROW_ONE  = 64'h0000_4000_0000_0000;
    localparam logic [63:0] RESET_POSE_ROW_TWO  = 64'h0000_0000_4000_0000;

    // Input pixel transaction
    typedef struct packed {
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
        logic [15:0] depth_q;
        logic [7:0]  mask_value;
        logic [7:0]  color_blue;
        logic [7:0]  color_green;
        logic [7:0]  color_red;
        logic        frame_end;
    } pixel_in_t;

    // Output point transaction
    typedef struct packed {
        logic               point_valid;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic signed [23:0] point_z;
        logic [7:0]         out_blue;
        logic [7:0]         out_green;
        logic [7:0]         out_red;
        logic               frame_last;
    } point_out_t;

    // Sideband carried down the pipeline next to the arithmetic
    typedef struct packed {
        logic       keep;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_end;
    } pix_side_t;

    // True when v is a multiple of the stride (reciprocal multiply, check back)
    function automatic logic is_stride_multiple(input logic [11:0] v);
        logic [36:0] prod;
        logic [11:0] quot;
        logic [16:0] back;
        prod = 37'(v) * 37'(STRIDE_RECIP);
        quot = prod[STRIDE_SHIFT +: 12];
        back = 17'(quot) * 17'(SUBSAMPLE_STRIDE);
        return back == 17'(v);
    endfunction

endpackage

FILE: design/depth_pixel_backprojection.sv
// Depth pixel back-projection top level: pinhole model and inverse pose, 8-stage pipeline.
// Stages: 8 register stages, the first one captures the input.
// Throughput: one pixel per cycle unless out_stall holds the pipeline; the stages split
// the keep test, three multiplies, row sums.
// Stalls reach in_stall in the same cycle; empty stages still fill while out_stall holds.
// Reset: rst_n clears all valid bits and loads the configuration defaults (identity pose).
`include "depth_pixel_backprojection_assert.svh"

module depth_pixel_backprojection (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  dpb_pkg::pixel_in_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output dpb_pkg::point_out_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dpb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [63:0]                        cfg_data
);

    // Configuration registers
    logic [23:0] recip_x_reg;
    logic [23:0] recip_y_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [63:0] pose_reg [3];

    // Pipeline control
    logic [dpb_pkg::NUM_STAGES-1:0] valid_reg;
    logic [dpb_pkg::NUM_STAGES-1:0] valid_next;
    logic [dpb_pkg::NUM_STAGES-1:0] stage_ready;

    // Stage 0: input capture
    dpb_pkg::pixel_in_t pix_reg;

    // Stage 1: filter and pixel offsets
    dpb_pkg::pix_side_t side1_reg, side1_next;
    logic signed [17:0] dx_reg, dx_next;
    logic signed [17:0] dy_reg, dy_next;
    logic [15:0]        depth1_reg;

    // Stage 2: offset times depth
    dpb_pkg::pix_side_t side2_reg;
    logic signed [34:0] dxd_full, dyd_full;
    logic signed [33:0] dxd_reg, dyd_reg;
    logic [15:0]        depth2_reg;

    // Stage 3: times reciprocal focal length
    dpb_pkg::pix_side_t side3_reg;
    logic signed [58:0] pxf_next, pyf_next;
    logic signed [58:0] pxf_reg, pyf_reg;
    logic signed [20:0] cz3_reg, cz3_next;

    // Stage 4: rounded camera point
    dpb_pkg::pix_side_t side4_reg;
    logic signed [58:0] pxr, pyr;
    logic signed [32:0] cx_reg, cx_next;
    logic signed [32:0] cy_reg, cy_next;
    logic signed [20:0] cz4_reg;

    // Stage 5: rotation products
    dpb_pkg::pix_side_t side5_reg;
    logic signed [48:0] prod_reg  [3][3];
    logic signed [48:0] prod_next [3][3];

    // Stage 6: row sums with translation and rounding offset
    dpb_pkg::pix_side_t side6_reg;
    logic signed [50:0] acc_reg  [3];
    logic signed [50:0] acc_next [3];

    // Stage 7: output register
    dpb_pkg::point_out_t out_reg, out_next;
    logic signed [32:0]  world [3];
    logic signed [23:0]  world_sat [3];

    // Saturate a rounded coordinate to signed Q12.12
    function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
        logic signed [23:0] r;
        if (v > dpb_pkg::OUT_MAX)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < dpb_pkg::OUT_MIN)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Accept every configuration write
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip_x_reg  <= dpb_pkg::RESET_RECIP_FOCAL;
            recip_y_reg  <= dpb_pkg::RESET_RECIP_FOCAL;
            center_x_reg <= dpb_pkg::RESET_CENTER_X;
            center_y_reg <= dpb_pkg::RESET_CENTER_Y;
            pose_reg[0]  <= dpb_pkg::RESET_POSE_ROW_ZERO;
            pose_reg[1]  <= dpb_pkg::RESET_POSE_ROW_ONE;
            pose_reg[2]  <= dpb_pkg::RESET_POSE_ROW_TWO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dpb_pkg::REG_RECIP_FOCAL_X: recip_x_reg  <= cfg_data[23:0];
                dpb_pkg::REG_RECIP_FOCAL_Y: recip_y_reg  <= cfg_data[23:0];
                dpb_pkg::REG_CENTER_X:      center_x_reg <= cfg_data[15:0];
                dpb_pkg::REG_CENTER_Y:      center_y_reg <= cfg_data[15:0];
                dpb_pkg::REG_POSE_ROW_ZERO: pose_reg[0]  <= cfg_data;
                dpb_pkg::REG_POSE_ROW_ONE:  pose_reg[1]  <= cfg_data;
                dpb_pkg::REG_POSE_ROW_TWO:  pose_reg[2]  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Propagate ready backward: a stage moves when empty or when the next one moves
    always_comb
    begin
        stage_ready[dpb_pkg::NUM_STAGES-1] = !valid_reg[dpb_pkg::NUM_STAGES-1] || !out_stall;
        for (int k = dpb_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k + 1];
        end
    end

    // Advance valid bits where the stage moves, hold elsewhere
    always_comb
    begin
        if (stage_ready[0])
        begin
            valid_next[0] = in_valid;
        end
        else
        begin
            valid_next[0] = valid_reg[0];
        end
        for (int k = 1; k < dpb_pkg::NUM_STAGES; k++)
        begin
            if (stage_ready[k])
            begin
                valid_next[k] = valid_reg[k - 1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall = !stage_ready[0];

    // Stage 1: keep test and offsets from the principal point
    always_comb
    begin
        side1_next.keep  = dpb_pkg::is_stride_multiple(pix_reg.pixel_row)
                        && dpb_pkg::is_stride_multiple(pix_reg.pixel_col)
                        && (pix_reg.depth_q >= dpb_pkg::DEPTH_MIN_Q)
                        && (pix_reg.depth_q <= dpb_pkg::DEPTH_MAX_Q)
                        && (pix_reg.mask_value == 8'd0);
        side1_next.blue      = pix_reg.color_blue;
        side1_next.green     = pix_reg.color_green;
        side1_next.red       = pix_reg.color_red;
        side1_next.frame_end = pix_reg.frame_end;
        dx_next = $signed({2'b00, pix_reg.pixel_col, 4'b0000}) - $signed({2'b00, center_x_reg});
        dy_next = $signed({2'b00, pix_reg.pixel_row, 4'b0000}) - $signed({2'b00, center_y_reg});
    end

    // Stage 2: scale offsets by depth
    always_comb
    begin
        dxd_full = dx_reg * $signed({1'b0, depth1_reg});
        dyd_full = dy_reg * $signed({1'b0, depth1_reg});
    end

    // Stage 3: scale by reciprocal focal lengths, form camera z
    always_comb
    begin
        pxf_next = dxd_reg * $signed({1'b0, recip_x_reg});
        pyf_next = dyd_reg * $signed({1'b0, recip_y_reg});
        cz3_next = $signed({1'b0, depth2_reg, 4'b0000});
    end

    // Stage 4: round half up to 2^-16 m
    always_comb
    begin
        pxr     = pxf_reg + 59'sd8388608;
        pyr     = pyf_reg + 59'sd8388608;
        cx_next = pxr[56:24];
        cy_next = pyr[56:24];
    end

    // Stage 5: multiply the camera point by each rotation row
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k][0] = $signed(pose_reg[k][63:48]) * cx_reg;
            prod_next[k][1] = $signed(pose_reg[k][47:32]) * cy_reg;
            prod_next[k][2] = $signed(pose_reg[k][31:16]) * cz4_reg;
        end
    end

    // Stage 6: sum products, add translation and rounding offset
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc_next[k] = prod_reg[k][0] + prod_reg[k][1] + prod_reg[k][2]
                        + $signed({pose_reg[k][15:0], 18'b0}) + 51'sd131072;
        end
    end

    // Stage 7: shift to Q12.12, saturate, zero rejected pixels
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            world[k]     = acc_reg[k][50:18];
            world_sat[k] = sat24(world[k]);
        end
        out_next = '0;
        out_next.frame_last = side6_reg.frame_end;
        if (side6_reg.keep)
        begin
            out_next.point_valid = 1'b1;
            out_next.point_x     = world_sat[0];
            out_next.point_y     = world_sat[1];
            out_next.point_z     = world_sat[2];
            out_next.out_blue    = side6_reg.blue;
            out_next.out_green   = side6_reg.green;
            out_next.out_red     = side6_reg.red;
        end
    end

    // Load payload registers where the stage moves
    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            pix_reg <= in_data;
        end
        if (stage_ready[1])
        begin
            side1_reg  <= side1_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            depth1_reg <= pix_reg.depth_q;
        end
        if (stage_ready[2])
        begin
            side2_reg  <= side1_reg;
            dxd_reg    <= dxd_full[33:0];
            dyd_reg    <= dyd_full[33:0];
            depth2_reg <= depth1_reg;
        end
        if (stage_ready[3])
        begin
            side3_reg <= side2_reg;
            pxf_reg   <= pxf_next;
            pyf_reg   <= pyf_next;
            cz3_reg   <= cz3_next;
        end
        if (stage_ready[4])
        begin
            side4_reg <= side3_reg;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            cz4_reg   <= cz3_reg;
        end
        if (stage_ready[5])
        begin
            side5_reg <= side4_reg;
            prod_reg  <= prod_next;
        end
        if (stage_ready[6])
        begin
            side6_reg <= side5_reg;
            acc_reg   <= acc_next;
        end
        if (stage_ready[7])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[dpb_pkg::NUM_STAGES-1];
    assign out_data  = out_reg;

    // A rejected pixel carries an all-zero point and color
    `DPB_ASSERT_IMP(a_reject_zero, clk, rst_n, out_valid && !out_data.point_valid, out_data.point_x == 24'sd0 && out_data.point_y == 24'sd0 && out_data.point_z == 24'sd0 && out_data.out_blue == 8'd0 && out_data.out_green == 8'd0 && out_data.out_red == 8'd0)
    // An accepted transaction always lands in the input stage
    `DPB_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_valid && !in_stall, valid_reg[0])
    // A stalled output keeps the item behind it in place
    `DPB_ASSERT_NEXT(a_stall_holds, clk, rst_n, valid_reg[dpb_pkg::NUM_STAGES-2] && out_valid && out_stall, valid_reg[dpb_pkg::NUM_STAGES-2] && out_valid)

endmodule

FILE: bench/dpb_checker.sv
`timescale 1ns / 100ps
// Checker for the depth pixel back-projection block: predicts each point and compares results.
module dpb_checker
    import dpb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  pixel_in_t              in_data,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  point_out_t             out_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    // Shadow copy of the camera and pose registers
    logic [23:0] focal_x;
    logic [23:0] focal_y;
    logic [15:0] ctr_x;
    logic [15:0] ctr_y;
    logic [63:0] pose [3];

    point_out_t pending_points [$];
    point_out_t want_point;

    initial mismatches = 0;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what);
        $display("[%0t] point mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // One world axis: rotation row dotted with the camera point plus translation,
    // rounded half up to Q12.12 and saturated
    function automatic logic [23:0] world_axis(input logic [63:0] row, input longint cam_x,
                                               input longint cam_y, input longint cam_z);
        longint acc;
        acc = longint'($signed(row[63:48])) * cam_x
            + longint'($signed(row[47:32])) * cam_y
            + longint'($signed(row[31:16])) * cam_z
            + longint'($signed(row[15:0])) * 64'sd262144;
        acc = (acc + 64'sd131072) >>> 18;
        if (acc > 64'sd8388607)
            acc = 64'sd8388607;
        if (acc < -64'sd8388608)
            acc = -64'sd8388608;
        return acc[23:0];
    endfunction

    // Expected point for one pixel under the current register settings
    function automatic point_out_t project_pixel(input pixel_in_t px);
        point_out_t pt;
        logic       keep;
        longint     off_x;
        longint     off_y;
        longint     cam_x;
        longint     cam_y;
        longint     cam_z;
        pt = '0;
        pt.frame_last = px.frame_end;
        keep = (px.pixel_row % SUBSAMPLE_STRIDE == 0) && (px.pixel_col % SUBSAMPLE_STRIDE == 0)
            && (px.depth_q >= DEPTH_MIN_Q) && (px.depth_q <= DEPTH_MAX_Q)
            && (px.mask_value == 8'd0);
        if (keep)
        begin
            off_x = longint'(px.pixel_col) * 16 - longint'(ctr_x);
            off_y = longint'(px.pixel_row) * 16 - longint'(ctr_y);
            cam_x = (off_x * longint'(px.depth_q) * longint'(focal_x) + 64'sd8388608) >>> 24;
            cam_y = (off_y * longint'(px.depth_q) * longint'(focal_y) + 64'sd8388608) >>> 24;
            cam_z = longint'(px.depth_q) * 16;
            pt.point_valid = 1'b1;
            pt.point_x = world_axis(pose[0], cam_x, cam_y, cam_z);
            pt.point_y = world_axis(pose[1], cam_x, cam_y, cam_z);
            pt.point_z = world_axis(pose[2], cam_x, cam_y, cam_z);
            pt.out_blue = px.color_blue;
            pt.out_green = px.color_green;
            pt.out_red = px.color_red;
        end
        return pt;
    endfunction

    // Track register writes, retire results, then queue new predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x = RESET_RECIP_FOCAL;
            focal_y = RESET_RECIP_FOCAL;
            ctr_x = RESET_CENTER_X;
            ctr_y = RESET_CENTER_Y;
            pose[0] = RESET_POSE_ROW_ZERO;
            pose[1] = RESET_POSE_ROW_ONE;
            pose[2] = RESET_POSE_ROW_TWO;
            pending_points.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RECIP_FOCAL_X: focal_x = cfg_data[23:0];
                    REG_RECIP_FOCAL_Y: focal_y = cfg_data[23:0];
                    REG_CENTER_X:      ctr_x = cfg_data[15:0];
                    REG_CENTER_Y:      ctr_y = cfg_data[15:0];
                    REG_POSE_ROW_ZERO: pose[0] = cfg_data;
                    REG_POSE_ROW_ONE:  pose[1] = cfg_data;
                    REG_POSE_ROW_TWO:  pose[2] = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_points.size() == 0)
                    report_mismatch("result transaction with no point expected");
                else
                begin
                    want_point = pending_points.pop_front();
                    check_field("point_valid", out_data.point_valid, want_point.point_valid);
                    check_field("point_x", out_data.point_x, want_point.point_x);
                    check_field("point_y", out_data.point_y, want_point.point_y);
                    check_field("point_z", out_data.point_z, want_point.point_z);
                    check_field("out_blue", out_data.out_blue, want_point.out_blue);
                    check_field("out_green", out_data.out_green, want_point.out_green);
                    check_field("out_red", out_data.out_red, want_point.out_red);
                    check_field("frame_last", out_data.frame_last, want_point.frame_last);
                end
            end
            if (in_valid && !in_stall)
                pending_points = {pending_points, project_pixel(in_data)};
            outstanding <= pending_points.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the depth pixel back-projection block: stimulus, pacing and verdict.
module tb_top;
    import dpb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PIPE_LATENCY = 8;
    localparam int PHASE_ITEMS  = 240;
    localparam int IDLE_PERCENT = 38;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    pixel_in_t              in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    point_out_t             out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = '0;
    int                     mismatches;
    int                     outstanding;

    logic receiver_steady = 1'b0;
    logic hold_request = 1'b0;
    logic hold_off = 1'b0;
    bit   sender_steady = 1'b0;
    int   cycle_count = 0;

    depth_pixel_backprojection dut (.*);

    dpb_checker point_checker (.*);

    // Clock and reset
    always #6 clk = ~clk;

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Long receiver hold-off so the pipeline fills and stalls its input
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Random result back-pressure
    always @(posedge clk)
        out_stall <= hold_off || (!receiver_steady && $urandom_range(99) < IDLE_PERCENT);

    function automatic pixel_in_t make_pixel(input int row, input int col, input int depth,
                                             input int mask, input int blue, input int green,
                                             input int red, input bit last);
        pixel_in_t p;
        p.pixel_row = 12'(row);
        p.pixel_col = 12'(col);
        p.depth_q = 16'(depth);
        p.mask_value = 8'(mask);
        p.color_blue = 8'(blue);
        p.color_green = 8'(green);
        p.color_red = 8'(red);
        p.frame_end = last;
        return p;
    endfunction

    // Mostly kept pixels with random content; the rest break one rule or are pure noise
    function automatic pixel_in_t random_pixel();
        pixel_in_t   p;
        int unsigned pick;
        pick = $urandom_range(99);
        p.pixel_row = 12'(SUBSAMPLE_STRIDE * $urandom_range(4095 / SUBSAMPLE_STRIDE));
        p.pixel_col = 12'(SUBSAMPLE_STRIDE * $urandom_range(4095 / SUBSAMPLE_STRIDE));
        p.depth_q = 16'($urandom_range(DEPTH_MAX_Q, DEPTH_MIN_Q));
        p.mask_value = 8'd0;
        p.color_blue = 8'($urandom);
        p.color_green = 8'($urandom);
        p.color_red = 8'($urandom);
        p.frame_end = ($urandom_range(15) == 0);
        if (pick < 10)
        begin
            p.pixel_row = 12'($urandom);
            p.pixel_col = 12'($urandom);
            p.depth_q = 16'($urandom);
            p.mask_value = 8'($urandom);
        end
        else if (pick < 30)
        begin
            case ($urandom_range(3))
                0: p.pixel_row = 12'($urandom);
                1: p.pixel_col = 12'($urandom);
                2: p.depth_q = 16'($urandom);
                default: p.mask_value = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    // Pose row: plausible rotations and any translation, or any 64 bits
    function automatic logic [63:0] random_pose_row(input bit any_bits);
        if (any_bits)
            return {$urandom, $urandom};
        return {16'(int'($urandom_range(32768)) - 16384), 16'(int'($urandom_range(32768)) - 16384),
                16'(int'($urandom_range(32768)) - 16384), 16'($urandom)};
    endfunction

    // Offer one pixel, idling first at random, and hold it until accepted
    task automatic send_pixel(input pixel_in_t p);
        while (!sender_steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Wait until every predicted point has come back
    task automatic wait_for_drain();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [23:0] fx, input logic [23:0] fy,
                                input logic [15:0] cx, input logic [15:0] cy,
                                input logic [63:0] row0, input logic [63:0] row1,
                                input logic [63:0] row2);
        write_reg(REG_RECIP_FOCAL_X, 64'(fx));
        write_reg(REG_RECIP_FOCAL_Y, 64'(fy));
        write_reg(REG_CENTER_X, 64'(cx));
        write_reg(REG_CENTER_Y, 64'(cy));
        write_reg(REG_POSE_ROW_ZERO, row0);
        write_reg(REG_POSE_ROW_ONE, row1);
        write_reg(REG_POSE_ROW_TWO, row2);
        cfg_valid <= 1'b0;
    endtask

    // One block of random pixels; optionally with the long receiver hold-off
    task automatic run_phase(input bit steady, input bit with_hold);
        int i;
        receiver_steady <= steady;
        sender_steady = steady;
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            if (with_hold && i == PHASE_ITEMS / 4)
            begin
                hold_request <= 1'b1;
                sender_steady = 1'b1;
            end
            if (with_hold && i == PHASE_ITEMS / 2)
                sender_steady = 1'b0;
            send_pixel(random_pixel());
        end
        in_valid <= 1'b0;
        wait_for_drain();
    endtask

    // Main stimulus
    initial
    begin
        wait (rst_n);
        @(posedge clk);

        // Directed pixels under the reset settings
        send_pixel(make_pixel(0, 0, 41, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(0, 0, 40, 0, 1, 2, 3, 0));
        send_pixel(make_pixel(3, 3, 40960, 0, 10, 20, 30, 0));
        send_pixel(make_pixel(3, 3, 40961, 0, 11, 21, 31, 1));
        send_pixel(make_pixel(0, 0, 0, 0, 255, 255, 255, 0));
        send_pixel(make_pixel(0, 0, 65535, 0, 7, 8, 9, 0));
        send_pixel(make_pixel(4095, 4095, 40960, 0, 255, 255, 255, 1));
        send_pixel(make_pixel(1, 0, 1000, 0, 40, 50, 60, 0));
        send_pixel(make_pixel(0, 2, 1000, 0, 41, 51, 61, 0));
        send_pixel(make_pixel(4094, 4093, 1000, 0, 42, 52, 62, 1));
        send_pixel(make_pixel(6, 9, 1000, 1, 43, 53, 63, 0));
        send_pixel(make_pixel(6, 9, 1000, 255, 44, 54, 64, 0));
        send_pixel(make_pixel(6, 9, 1000, 128, 45, 55, 65, 1));
        send_pixel(make_pixel(240, 321, 4096, 0, 128, 64, 32, 0));
        send_pixel(make_pixel(2049, 2052, 20000, 0, 85, 170, 15, 0));
        send_pixel(make_pixel(4095, 0, 40960, 0, 1, 0, 254, 0));
        send_pixel(make_pixel(0, 4095, 40960, 0, 0, 254, 1, 1));
        send_pixel(make_pixel(4095, 4095, 41, 0, 200, 100, 50, 0));
        send_pixel(make_pixel(3, 0, 42, 0, 17, 34, 51, 0));
        send_pixel(make_pixel(4095, 4095, 65535, 255, 255, 255, 255, 1));
        in_valid <= 1'b0;
        wait_for_drain();

        // Reset settings, then the extremes, then plausible and arbitrary settings
        run_phase(1'b0, 1'b0);
        program_regs(24'hFF_FFFF, 24'hFF_FFFF, 16'h0000, 16'h0000, {4{16'h7FFF}},
                     {4{16'h7FFF}}, {4{16'h7FFF}});
        run_phase(1'b1, 1'b0);
        program_regs(24'h00_0000, 24'h00_0000, 16'hFFFF, 16'hFFFF, {4{16'h8000}},
                     {4{16'h8000}}, {4{16'h8000}});
        run_phase(1'b0, 1'b0);
        program_regs(24'($urandom_range(56000, 18000)), 24'($urandom_range(56000, 18000)),
                     16'($urandom_range(32000, 2000)), 16'($urandom_range(32000, 2000)),
                     random_pose_row(1'b0), random_pose_row(1'b0), random_pose_row(1'b0));
        run_phase(1'b0, 1'b1);
        program_regs(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                     random_pose_row(1'b1), random_pose_row(1'b1), random_pose_row(1'b1));
        run_phase(1'b0, 1'b0);
        program_regs(24'($urandom_range(56000, 18000)), 24'($urandom_range(56000, 18000)),
                     16'($urandom_range(32000, 2000)), 16'($urandom_range(32000, 2000)),
                     random_pose_row(1'b0), random_pose_row(1'b0), random_pose_row(1'b0));
        run_phase(1'b0, 1'b0);

        // Let any stray result surface before the verdict
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
